### hdl/gbn_pkg.sv
package gbn_pkg;

  localparam int SEQ_W = 4;
  localparam int SEQ_SPACE = 1 << SEQ_W;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [SEQ_W-1:0] seq_t;

  localparam logic [3:0] WIN_RESET = 4'd4;
  localparam logic [1:0] DUP_MAX = 2'd3;

  // request codes on s_tuser
  localparam logic [1:0] REQ_SEND = 2'd0;
  localparam logic [1:0] REQ_ACK  = 2'd1;
  localparam logic [1:0] REQ_TMO  = 2'd2;

  // action codes on m_tuser
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_SEND   = 2'd1;
  localparam logic [1:0] ACT_RETX   = 2'd2;
  localparam logic [1:0] ACT_REFUSE = 2'd3;

  // timer commands
  localparam logic [1:0] TMR_LEAVE = 2'd0;
  localparam logic [1:0] TMR_START = 2'd1;
  localparam logic [1:0] TMR_STOP  = 2'd2;

  typedef enum logic [1:0] {
    K_SEND = 2'd0,
    K_ACK  = 2'd1,
    K_TMO  = 2'd2,
    K_NOP  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    seq_t  ack;
  } cmd_t;

endpackage

### hdl/gbn_queue.sv
module gbn_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // ack_seq[3:0], ack_check_ok[4], zero pad
  input  logic [1:0]  s_tuser,   // req_type
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output gbn_pkg::cmd_t cmd
);
  import gbn_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  cmd_t             in_cmd;
  logic             push;
  logic             pop;

  // classify the request; a failed checksum or unknown code does nothing
  always_comb begin
    in_cmd.ack = s_tdata[SEQ_W-1:0];
    case (s_tuser)
      REQ_SEND: in_cmd.kind = K_SEND;
      REQ_ACK:  in_cmd.kind = s_tdata[SEQ_W] ? K_ACK : K_NOP;
      REQ_TMO:  in_cmd.kind = K_TMO;
      default:  in_cmd.kind = K_NOP;
    endcase
  end

  assign s_tready  = (count != CNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= in_cmd;
  end

endmodule

### hdl/gbn_back.sv
module gbn_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [3:0]    cfg_wr_data,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  gbn_pkg::cmd_t cmd,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,   // seq_number[3:0], timer_cmd[5:4], zero pad
  output logic [1:0]    m_tuser,   // action
  output logic          m_tlast
);
  import gbn_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_REPLAY = 2'b10
  } state_t;

  state_t     state, state_next;
  logic [3:0] window_size;
  seq_t       lower_edge, lower_edge_next;
  seq_t       next_seq, next_seq_next;
  logic [1:0] dup_count [SEQ_SPACE];
  logic       fast_done [SEQ_SPACE];
  seq_t       rep_seq, rep_seq_next;
  seq_t       rep_left, rep_left_next;

  seq_t       outstanding;
  seq_t       below;
  logic [1:0] dc_inc;
  logic       dc_we, fd_we, fd_val;
  logic [1:0] dc_val;
  logic       out_free, take, load;
  logic [1:0] o_act, o_tmr;
  seq_t       o_seq;
  logic       o_last;

  assign out_free    = !m_tvalid || m_tready;
  assign cmd_ready   = (state == ST_IDLE) && out_free;
  assign take        = cmd_valid && cmd_ready;
  assign outstanding = next_seq - lower_edge;
  assign below       = lower_edge - SEQ_W'(1);
  assign dc_inc      = (dup_count[cmd.ack] == DUP_MAX) ? DUP_MAX
                                                       : dup_count[cmd.ack] + 2'd1;

  always_comb begin
    state_next      = state;
    lower_edge_next = lower_edge;
    next_seq_next   = next_seq;
    rep_seq_next    = rep_seq;
    rep_left_next   = rep_left;
    dc_we  = 1'b0;
    dc_val = dc_inc;
    fd_we  = 1'b0;
    fd_val = 1'b0;
    load   = 1'b0;
    o_act  = ACT_NONE;
    o_seq  = '0;
    o_tmr  = TMR_LEAVE;
    o_last = 1'b1;
    case (state)
      ST_IDLE: begin
        if (take) begin
          load = 1'b1;
          case (cmd.kind)
            K_SEND: begin
              // window_size is 4 bits, so it never exceeds SEQ_SPACE - 1
              if (outstanding < window_size) begin
                o_act = ACT_SEND;
                o_seq = next_seq;
                o_tmr = (outstanding == '0) ? TMR_START : TMR_LEAVE;
                next_seq_next = next_seq + SEQ_W'(1);
              end else begin
                o_act = ACT_REFUSE;
              end
            end
            K_ACK: begin
              if (cmd.ack == below) begin
                dc_we = 1'b1;
                if (dc_inc == DUP_MAX && !fast_done[cmd.ack]) begin
                  fd_we  = 1'b1;
                  fd_val = 1'b1;
                  if (outstanding != '0) begin
                    o_act = ACT_RETX;
                    o_seq = lower_edge;
                    o_tmr = TMR_START;
                  end
                end
              end else if (seq_t'(cmd.ack - lower_edge) < outstanding) begin
                lower_edge_next = cmd.ack + SEQ_W'(1);
                dc_we  = 1'b1;
                dc_val = '0;
                fd_we  = 1'b1;
                o_tmr  = (lower_edge_next == next_seq) ? TMR_STOP : TMR_LEAVE;
              end
            end
            K_TMO: begin
              o_tmr = TMR_START;
              if (outstanding != '0) begin
                o_act  = ACT_RETX;
                o_seq  = lower_edge;
                o_last = (outstanding == SEQ_W'(1));
                rep_seq_next  = lower_edge + SEQ_W'(1);
                rep_left_next = outstanding - SEQ_W'(1);
                if (outstanding != SEQ_W'(1)) state_next = ST_REPLAY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_REPLAY: begin
        if (out_free) begin
          load   = 1'b1;
          o_act  = ACT_RETX;
          o_seq  = rep_seq;
          o_last = (rep_left == SEQ_W'(1));
          rep_seq_next  = rep_seq + SEQ_W'(1);
          rep_left_next = rep_left - SEQ_W'(1);
          if (rep_left == SEQ_W'(1)) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      window_size <= WIN_RESET;
      lower_edge  <= '0;
      next_seq    <= '0;
      m_tvalid    <= 1'b0;
      for (int i = 0; i < SEQ_SPACE; i++) begin
        dup_count[i] <= '0;
        fast_done[i] <= 1'b0;
      end
    end else begin
      state      <= state_next;
      lower_edge <= lower_edge_next;
      next_seq   <= next_seq_next;
      if (cfg_wr_en) window_size <= cfg_wr_data;
      if (load)          m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (dc_we) dup_count[cmd.ack] <= dc_val;
      if (fd_we) fast_done[cmd.ack] <= fd_val;
    end
  end

  always_ff @(posedge clk) begin
    rep_seq  <= rep_seq_next;
    rep_left <= rep_left_next;
    if (load) begin
      m_tdata <= {2'b00, o_tmr, o_seq};
      m_tuser <= o_act;
      m_tlast <= o_last;
    end
  end

endmodule

### hdl/go_back_n_sender_window.sv
// go-back-n sender window: sequence numbering and timer control
//
// input channel (s_*): one item per event. s_tuser is the request kind
// (send, ack, timeout), s_tdata carries the ack number and checksum flag.
// output channel (m_*): one or more items per input. m_tuser is the action
// (none, send new, retransmit, refused), m_tdata the sequence number and the
// timer command, m_tlast marks the final item of the input.
// config: cfg_wr_en / cfg_wr_data write the window size (reset value 4).
//
// a two-entry queue decouples input acceptance from the sequencing core.
// the first result passes through the queue entry and then the output register.
// throughput: each send or ack yields one result; a timeout with n packets
// outstanding yields n retransmits, one per cycle through the output register
// while the receiver does not stall, so the output port sets the pace, and the
// core takes no new request until the replay is done.
// when the receiver stalls, the output register holds its item and the
// queue keeps taking input until both entries are full.
// reset (rst, synchronous) empties the queue, clears the window edges and
// all duplicate-ack counters, and sets the window size back to 4.
module go_back_n_sender_window (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,  // window_size
  // request stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,      // ack_seq[3:0], ack_check_ok[4], zero pad
  input  logic [1:0] s_tuser,      // req_type
  // result stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,      // seq_number[3:0], timer_cmd[5:4], zero pad
  output logic [1:0] m_tuser,      // action
  output logic       m_tlast       // last
);
  import gbn_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // front: classify requests and buffer them
  gbn_queue u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // back: window state, dup-ack tracking, replay sequencer, output register
  gbn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

### hdl/gbn_checker.sv
module gbn_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);
  import gbn_pkg::*;

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // sends and refusals are always single results
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ACT_SEND || m_tuser == ACT_REFUSE) |-> m_tlast)
    else $error("send or refusal not marked last");

  // replay continues with the next number in the following cycle
  a_replay: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && m_tuser == ACT_RETX &&
      m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1)
    else $error("replay sequence broken");

  // empty and refused results carry no sequence number
  a_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ACT_NONE || m_tuser == ACT_REFUSE) |->
      m_tdata[3:0] == 4'd0)
    else $error("sequence number on empty result");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind go_back_n_sender_window gbn_checker u_chk (.*);
